// ===== rtl/sia_pkg.sv =====
// Shared constants for the segment intersection block.
`default_nettype none
package sia_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH     = 4;
endpackage
`default_nettype wire

// ===== rtl/sia_fifo.sv =====
// Small first-in first-out queue with push/full and pop/empty sides.
`default_nettype none
module sia_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = sia_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  output logic              full,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      dout
);
  import sia_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [0:DEPTH-1];
  logic [AW:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]  rd_ptr_r, rd_ptr_nxt;
  logic         do_push, do_pop;

  assign full    = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r[AW-1:0]];

  assign wr_ptr_nxt = wr_ptr_r + (AW+1)'(do_push);
  assign rd_ptr_nxt = rd_ptr_r + (AW+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r[AW-1:0]] <= din;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/sia_front.sv =====
// Front part: box test, differences, cross products and hit classification.
`default_nettype none
module sia_front #(
  parameter int COORD_WIDTH = sia_pkg::COORD_WIDTH_DEF,
  parameter int MW          = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_end_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_end_y,
  output logic                               mid_push,
  input  wire logic                          mid_full,
  output logic [MW-1:0]                      mid_din
);
  import sia_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int D  = CW + 1;
  localparam int P  = 2 * D;
  localparam int XW = P + 1;

  logic adv, take;

  // Stage 1 registers
  logic                 f1_vld_r;
  logic                 f1_bb_r;
  logic signed [CW-1:0] f1_ax0_r, f1_ay0_r;
  logic signed [D-1:0]  f1_dax_r, f1_day_r, f1_dbx_r, f1_dby_r, f1_ex_r, f1_ey_r;
  // Stage 2 registers
  logic                 f2_vld_r;
  logic                 f2_bb_r;
  logic signed [CW-1:0] f2_ax0_r, f2_ay0_r;
  logic signed [D-1:0]  f2_dax_r, f2_day_r;
  logic signed [P-1:0]  f2_p0_r, f2_p1_r, f2_p2_r, f2_p3_r, f2_p4_r, f2_p5_r;
  // Stage 3 registers
  logic                 f3_vld_r;
  logic                 f3_bb_r;
  logic signed [CW-1:0] f3_ax0_r, f3_ay0_r;
  logic signed [D-1:0]  f3_dax_r, f3_day_r;
  logic signed [XW-1:0] f3_den_r, f3_tn_r, f3_sn_r;
  // Stage 4 registers
  logic                 f4_vld_r;
  logic                 f4_bb_r;
  logic signed [CW-1:0] f4_ax0_r, f4_ay0_r;
  logic signed [D-1:0]  f4_dax_r, f4_day_r;
  logic signed [XW-1:0] f4_den_r, f4_tn_r, f4_sn_r;

  logic signed [CW-1:0] amax_x, amin_x, amax_y, amin_y;
  logic signed [CW-1:0] bmax_x, bmin_x, bmax_y, bmin_y;
  logic                 bb_ok;
  logic signed [P-1:0]  p0_w, p1_w, p2_w, p3_w, p4_w, p5_w;
  logic                 flip;
  logic                 pass;

  assign adv     = !(f4_vld_r && mid_full);
  assign in_full = !adv;
  assign take    = in_push && adv;

  assign amax_x = (in_a_start_x > in_a_end_x) ? in_a_start_x : in_a_end_x;
  assign amin_x = (in_a_start_x < in_a_end_x) ? in_a_start_x : in_a_end_x;
  assign amax_y = (in_a_start_y > in_a_end_y) ? in_a_start_y : in_a_end_y;
  assign amin_y = (in_a_start_y < in_a_end_y) ? in_a_start_y : in_a_end_y;
  assign bmax_x = (in_b_start_x > in_b_end_x) ? in_b_start_x : in_b_end_x;
  assign bmin_x = (in_b_start_x < in_b_end_x) ? in_b_start_x : in_b_end_x;
  assign bmax_y = (in_b_start_y > in_b_end_y) ? in_b_start_y : in_b_end_y;
  assign bmin_y = (in_b_start_y < in_b_end_y) ? in_b_start_y : in_b_end_y;
  // Boxes that only touch still pass.
  assign bb_ok = !((amax_x < bmin_x) || (bmax_x < amin_x) ||
                   (amax_y < bmin_y) || (bmax_y < amin_y));

  assign p0_w = f1_dax_r * f1_dby_r;
  assign p1_w = f1_day_r * f1_dbx_r;
  assign p2_w = f1_ex_r * f1_dby_r;
  assign p3_w = f1_ey_r * f1_dbx_r;
  assign p4_w = f1_ex_r * f1_day_r;
  assign p5_w = f1_ey_r * f1_dax_r;

  assign flip = f3_den_r[XW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
      f4_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= take;
      f2_vld_r <= f1_vld_r;
      f3_vld_r <= f2_vld_r;
      f4_vld_r <= f3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_bb_r  <= bb_ok;
      f1_ax0_r <= in_a_start_x;
      f1_ay0_r <= in_a_start_y;
      f1_dax_r <= D'(in_a_end_x) - D'(in_a_start_x);
      f1_day_r <= D'(in_a_end_y) - D'(in_a_start_y);
      f1_dbx_r <= D'(in_b_end_x) - D'(in_b_start_x);
      f1_dby_r <= D'(in_b_end_y) - D'(in_b_start_y);
      f1_ex_r  <= D'(in_b_start_x) - D'(in_a_start_x);
      f1_ey_r  <= D'(in_b_start_y) - D'(in_a_start_y);

      f2_bb_r  <= f1_bb_r;
      f2_ax0_r <= f1_ax0_r;
      f2_ay0_r <= f1_ay0_r;
      f2_dax_r <= f1_dax_r;
      f2_day_r <= f1_day_r;
      f2_p0_r  <= p0_w;
      f2_p1_r  <= p1_w;
      f2_p2_r  <= p2_w;
      f2_p3_r  <= p3_w;
      f2_p4_r  <= p4_w;
      f2_p5_r  <= p5_w;

      f3_bb_r  <= f2_bb_r;
      f3_ax0_r <= f2_ax0_r;
      f3_ay0_r <= f2_ay0_r;
      f3_dax_r <= f2_dax_r;
      f3_day_r <= f2_day_r;
      f3_den_r <= XW'(f2_p0_r) - XW'(f2_p1_r);
      f3_tn_r  <= XW'(f2_p2_r) - XW'(f2_p3_r);
      f3_sn_r  <= XW'(f2_p4_r) - XW'(f2_p5_r);

      // Flip all three signs so the denominator is positive.
      f4_bb_r  <= f3_bb_r;
      f4_ax0_r <= f3_ax0_r;
      f4_ay0_r <= f3_ay0_r;
      f4_dax_r <= f3_dax_r;
      f4_day_r <= f3_day_r;
      f4_den_r <= flip ? -f3_den_r : f3_den_r;
      f4_tn_r  <= flip ? -f3_tn_r : f3_tn_r;
      f4_sn_r  <= flip ? -f3_sn_r : f3_sn_r;
    end
  end

  assign pass = f4_bb_r && (f4_den_r != '0) &&
                !f4_tn_r[XW-1] && (f4_tn_r <= f4_den_r) &&
                !f4_sn_r[XW-1] && (f4_sn_r <= f4_den_r);

  assign mid_push = f4_vld_r && !mid_full;
  assign mid_din  = {pass, f4_ax0_r, f4_ay0_r, f4_dax_r, f4_day_r, f4_tn_r, f4_den_r};
endmodule
`default_nettype wire

// ===== rtl/sia_back.sv =====
// Back part: point numerators and a pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module sia_back #(
  parameter int COORD_WIDTH = sia_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sia_pkg::FRAC_BITS_DEF,
  parameter int MW          = 8,
  parameter int OW          = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          mid_empty,
  output logic               mid_pop,
  input  wire logic [MW-1:0] mid_dout,
  output logic               res_push,
  input  wire logic          res_full,
  output logic [OW-1:0]      res_din
);
  import sia_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int D  = CW + 1;
  localparam int XW = 2 * D + 1;
  localparam int PA = CW + XW;
  localparam int PT = XW + D;
  localparam int NW = PT + 1;
  localparam int RW = NW + FRAC_BITS;
  localparam int QW = CW + FRAC_BITS;

  logic                 m_pass;
  logic signed [CW-1:0] m_ax0, m_ay0;
  logic signed [D-1:0]  m_dax, m_day;
  logic signed [XW-1:0] m_tn, m_den;
  logic signed [PA-1:0] pax_w, pay_w;
  logic signed [PT-1:0] ptx_w, pty_w;
  logic                 adv;

  logic                 b1_vld_r, b1_pass_r;
  logic signed [PA-1:0] b1_pax_r, b1_pay_r;
  logic signed [PT-1:0] b1_ptx_r, b1_pty_r;
  logic [XW-1:0]        b1_den_r;

  logic signed [NW-1:0] numx, numy;
  logic [NW-1:0]        magx, magy;

  logic          dv_vld_r  [0:QW];
  logic          dv_pass_r [0:QW];
  logic          dv_negx_r [0:QW];
  logic          dv_negy_r [0:QW];
  logic [XW-1:0] dv_den_r  [0:QW];
  logic [RW-1:0] dv_remx_r [0:QW];
  logic [RW-1:0] dv_remy_r [0:QW];
  logic [QW-1:0] dv_qx_r   [0:QW];
  logic [QW-1:0] dv_qy_r   [0:QW];

  logic [QW-1:0] resx, resy;

  assign {m_pass, m_ax0, m_ay0, m_dax, m_day, m_tn, m_den} = mid_dout;

  assign adv     = !(dv_vld_r[QW] && res_full);
  assign mid_pop = adv;

  assign pax_w = m_ax0 * m_den;
  assign pay_w = m_ay0 * m_den;
  assign ptx_w = m_tn * m_dax;
  assign pty_w = m_tn * m_day;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r    <= 1'b0;
      dv_vld_r[0] <= 1'b0;
    end else if (adv) begin
      b1_vld_r    <= !mid_empty;
      dv_vld_r[0] <= b1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_pass_r <= m_pass;
      b1_pax_r  <= pax_w;
      b1_pay_r  <= pay_w;
      b1_ptx_r  <= ptx_w;
      b1_pty_r  <= pty_w;
      b1_den_r  <= m_den;
    end
  end

  assign numx = NW'(b1_pax_r) + NW'(b1_ptx_r);
  assign numy = NW'(b1_pay_r) + NW'(b1_pty_r);
  assign magx = numx[NW-1] ? -numx : numx;
  assign magy = numy[NW-1] ? -numy : numy;

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_pass_r[0] <= b1_pass_r;
      dv_negx_r[0] <= numx[NW-1];
      dv_negy_r[0] <= numy[NW-1];
      dv_den_r[0]  <= b1_den_r;
      dv_remx_r[0] <= RW'(magx) << FRAC_BITS;
      dv_remy_r[0] <= RW'(magy) << FRAC_BITS;
      dv_qx_r[0]   <= '0;
      dv_qy_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int B = QW - k;
    logic [RW-1:0] trial;
    logic          gex, gey;

    assign trial = RW'(dv_den_r[k-1]) << B;
    assign gex   = dv_remx_r[k-1] >= trial;
    assign gey   = dv_remy_r[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_pass_r[k] <= dv_pass_r[k-1];
        dv_negx_r[k] <= dv_negx_r[k-1];
        dv_negy_r[k] <= dv_negy_r[k-1];
        dv_den_r[k]  <= dv_den_r[k-1];
        dv_remx_r[k] <= gex ? dv_remx_r[k-1] - trial : dv_remx_r[k-1];
        dv_remy_r[k] <= gey ? dv_remy_r[k-1] - trial : dv_remy_r[k-1];
        dv_qx_r[k]   <= dv_qx_r[k-1] | (gex ? (QW'(1) << B) : '0);
        dv_qy_r[k]   <= dv_qy_r[k-1] | (gey ? (QW'(1) << B) : '0);
      end
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign resx = dv_negx_r[QW] ? -dv_qx_r[QW] : dv_qx_r[QW];
  assign resy = dv_negy_r[QW] ? -dv_qy_r[QW] : dv_qy_r[QW];

  assign res_push = dv_vld_r[QW] && !res_full;
  assign res_din  = dv_pass_r[QW] ? {1'b1, resx, resy} : '0;
endmodule
`default_nettype wire

// ===== rtl/segment_intersection_2d_top.sv =====
// Segment intersection top level: front classifier, queue, divider back end, result queue.
// Takes one segment pair per clock while in_full is low and returns one result per pair,
// in order. Both channels are queues: push an item while full is low, take a result while
// empty is low. Throughput is one pair per cycle while neither queue is full; from the
// accepting edge to the result on the ports a pair passes four front stages, the middle
// queue, one numerator stage, the divider input stage, one restoring divider stage per
// quotient bit and the result queue. A result is the hit flag and the crossing point
// A0+t*(A1-A0) with FRAC_BITS fraction bits, truncated toward zero; parallel pairs,
// disjoint boxes and t or s outside [0,1] give no hit and a zero point.
`default_nettype none
module segment_intersection_2d_top #(
  parameter int COORD_WIDTH = sia_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sia_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_push,
  output logic                                         in_full,
  input  wire logic signed [COORD_WIDTH-1:0]           in_a_start_x,
  input  wire logic signed [COORD_WIDTH-1:0]           in_a_start_y,
  input  wire logic signed [COORD_WIDTH-1:0]           in_a_end_x,
  input  wire logic signed [COORD_WIDTH-1:0]           in_a_end_y,
  input  wire logic signed [COORD_WIDTH-1:0]           in_b_start_x,
  input  wire logic signed [COORD_WIDTH-1:0]           in_b_start_y,
  input  wire logic signed [COORD_WIDTH-1:0]           in_b_end_x,
  input  wire logic signed [COORD_WIDTH-1:0]           in_b_end_y,
  output logic                                         out_empty,
  input  wire logic                                    out_pop,
  output logic                                         out_hit,
  output logic signed [COORD_WIDTH+FRAC_BITS-1:0]      out_cross_x,
  output logic signed [COORD_WIDTH+FRAC_BITS-1:0]      out_cross_y
);
  import sia_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int D  = CW + 1;
  localparam int XW = 2 * D + 1;
  localparam int MW = 1 + 2 * CW + 2 * D + 2 * XW;
  localparam int QW = CW + FRAC_BITS;
  localparam int OW = 1 + 2 * QW;

  logic          mid_push, mid_full, mid_pop, mid_empty;
  logic [MW-1:0] mid_din, mid_dout;
  logic          res_push, res_full;
  logic [OW-1:0] res_din, res_dout;

  sia_front #(.COORD_WIDTH(COORD_WIDTH), .MW(MW)) u_front (
    .clk, .rst_n, .in_push, .in_full,
    .in_a_start_x, .in_a_start_y, .in_a_end_x, .in_a_end_y,
    .in_b_start_x, .in_b_start_y, .in_b_end_x, .in_b_end_y,
    .mid_push, .mid_full, .mid_din
  );

  sia_fifo #(.W(MW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk, .rst_n, .push(mid_push), .full(mid_full), .din(mid_din),
    .pop(mid_pop), .empty(mid_empty), .dout(mid_dout)
  );

  sia_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .MW(MW), .OW(OW)) u_back (
    .clk, .rst_n, .mid_empty, .mid_pop, .mid_dout,
    .res_push, .res_full, .res_din
  );

  sia_fifo #(.W(OW), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk, .rst_n, .push(res_push), .full(res_full), .din(res_din),
    .pop(out_pop), .empty(out_empty), .dout(res_dout)
  );

  assign {out_hit, out_cross_x, out_cross_y} = res_dout;
endmodule
`default_nettype wire

// ===== rtl/sia_chk.sv =====
// Port-level checker for the segment intersection top level, with its bind.
`default_nettype none
module sia_chk #(
  parameter int COORD_WIDTH = sia_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sia_pkg::FRAC_BITS_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_push,
  input wire logic                               in_full,
  input wire logic [COORD_WIDTH-1:0]             in_a_start_x,
  input wire logic [COORD_WIDTH-1:0]             in_a_start_y,
  input wire logic [COORD_WIDTH-1:0]             in_a_end_x,
  input wire logic [COORD_WIDTH-1:0]             in_a_end_y,
  input wire logic [COORD_WIDTH-1:0]             in_b_start_x,
  input wire logic [COORD_WIDTH-1:0]             in_b_start_y,
  input wire logic [COORD_WIDTH-1:0]             in_b_end_x,
  input wire logic [COORD_WIDTH-1:0]             in_b_end_y,
  input wire logic                               out_empty,
  input wire logic                               out_pop,
  input wire logic                               out_hit,
  input wire logic [COORD_WIDTH+FRAC_BITS-1:0]   out_cross_x,
  input wire logic [COORD_WIDTH+FRAC_BITS-1:0]   out_cross_y
);
  import sia_pkg::*;

  // After reset nothing is queued and the input side is open.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not clear after reset");

  // A miss always carries a zero point.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_hit |-> out_cross_x == '0 && out_cross_y == '0)
    else $error("miss with nonzero point");

  // A waiting result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_hit) &&
    $stable(out_cross_x) && $stable(out_cross_y))
    else $error("waiting result changed");

  // A waiting result beat always carries known values.
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !$isunknown({out_hit, out_cross_x, out_cross_y}))
    else $error("waiting result has unknown bits");
endmodule

bind segment_intersection_2d_top sia_chk #(
  .COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)
) u_sia_chk (.*);
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the segment intersection top level.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import sia_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int OW = CW + FB;
  localparam int LATENCY = CW + FB + 8;
  localparam int STALL_LIMIT = 20000;
  localparam int N_RANDOM = 1130;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;
  typedef struct {
    logic          hit;
    logic [OW-1:0] cx;
    logic [OW-1:0] cy;
  } crossing_t;

  // Fixed-point coordinate of p0 + (tn/den)*d, truncated toward zero.
  function automatic logic [OW-1:0] crossing_coord(longint p0, longint d, longint tn,
                                                    longint den);
    longint num;
    longint unsigned mag, q, r, res;
    num = p0 * den + tn * d;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    r = mag % den;
    res = (q << FB) + ((r << FB) / den);
    if (num < 0) res = -res;
    return res[OW-1:0];
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t p);
    crossing_t c;
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint dax, day, dbx, dby, ex, ey, den, tn, sn;
    c = '{1'b0, '0, '0};
    ax0 = p.ax0; ay0 = p.ay0; ax1 = p.ax1; ay1 = p.ay1;
    bx0 = p.bx0; by0 = p.by0; bx1 = p.bx1; by1 = p.by1;
    if ((ax0 > ax1 ? ax0 : ax1) < (bx0 < bx1 ? bx0 : bx1)) return c;
    if ((bx0 > bx1 ? bx0 : bx1) < (ax0 < ax1 ? ax0 : ax1)) return c;
    if ((ay0 > ay1 ? ay0 : ay1) < (by0 < by1 ? by0 : by1)) return c;
    if ((by0 > by1 ? by0 : by1) < (ay0 < ay1 ? ay0 : ay1)) return c;
    dax = ax1 - ax0; day = ay1 - ay0;
    dbx = bx1 - bx0; dby = by1 - by0;
    ex = bx0 - ax0; ey = by0 - ay0;
    den = dax * dby - day * dbx;
    if (den == 0) return c;
    tn = ex * dby - ey * dbx;
    sn = ex * day - ey * dax;
    if (den < 0) begin
      den = -den; tn = -tn; sn = -sn;
    end
    if (tn < 0 || tn > den || sn < 0 || sn > den) return c;
    c.hit = 1'b1;
    c.cx = crossing_coord(ax0, dax, tn, den);
    c.cy = crossing_coord(ay0, day, tn, den);
    return c;
  endfunction

  class crossing_board;
    crossing_t pending[$];
    int errors = 0;
    int hits = 0;
    int checked = 0;

    function void note_pair(seg_pair_t p);
      pending.push_back(predict_crossing(p));
    endfunction

    function void check_result(logic hit, logic [OW-1:0] cx, logic [OW-1:0] cy);
      crossing_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.hit) hits++;
      if (hit !== e.hit) begin
        $error("hit: expected %0d, actual %0d", e.hit, hit); errors++;
      end
      if (cx !== e.cx) begin
        $error("cross_x: expected %0d, actual %0d", $signed(e.cx), $signed(cx)); errors++;
      end
      if (cy !== e.cy) begin
        $error("cross_y: expected %0d, actual %0d", $signed(e.cy), $signed(cy)); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_push, in_full, out_empty, out_pop, out_hit;
  coord_t in_a_start_x, in_a_start_y, in_a_end_x, in_a_end_y;
  coord_t in_b_start_x, in_b_start_y, in_b_end_x, in_b_end_y;
  logic signed [OW-1:0] out_cross_x, out_cross_y;

  crossing_board board;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;

  segment_intersection_2d_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_a_start_x(in_a_start_x), .in_a_start_y(in_a_start_y),
    .in_a_end_x(in_a_end_x), .in_a_end_y(in_a_end_y),
    .in_b_start_x(in_b_start_x), .in_b_start_y(in_b_start_y),
    .in_b_end_x(in_b_end_x), .in_b_end_y(in_b_end_y),
    .out_empty(out_empty), .out_pop(out_pop), .out_hit(out_hit),
    .out_cross_x(out_cross_x), .out_cross_y(out_cross_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: pop at random, check each accepted result beat.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) board.check_result(out_hit, out_cross_x, out_cross_y);
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_pair(seg_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    {in_a_start_x, in_a_start_y, in_a_end_x, in_a_end_y} <= {p.ax0, p.ay0, p.ax1, p.ay1};
    {in_b_start_x, in_b_start_y, in_b_end_x, in_b_end_y} <= {p.bx0, p.by0, p.bx1, p.by1};
    @(posedge clk);
    while (in_full) @(posedge clk);
    board.note_pair(p);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  // About half the pairs are built to cross around a shared point; the rest are broad noise.
  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int span, cx, cy;
    span = ($urandom_range(3) == 0) ? 0 : (($urandom_range(1) == 0) ? 100 : 16000);
    p = '{rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
          rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)};
    if (span != 0 && $urandom_range(2) != 0) begin
      cx = int'(rand_coord(span)); cy = int'(rand_coord(span));
      p.ax1 = coord_t'(2 * cx - p.ax0); p.ay1 = coord_t'(2 * cy - p.ay0);
      p.bx1 = coord_t'(2 * cx - p.bx0); p.by1 = coord_t'(2 * cy - p.by0);
    end
    case ($urandom_range(15))
      0: begin p.bx1 = p.bx0; p.by1 = p.by0; end
      1: begin p.bx0 = p.ax1; p.by0 = p.ay1; end
      default: ;
    endcase
    return p;
  endfunction

  localparam coord_t MX = 16'sh7fff;
  localparam coord_t MN = -16'sh8000;

  initial begin
    seg_pair_t directed[$];
    board = new();
    rst_n = 1'b0;
    in_push = 1'b0;
    out_pop = 1'b0;
    {in_a_start_x, in_a_start_y, in_a_end_x, in_a_end_y} = '0;
    {in_b_start_x, in_b_start_y, in_b_end_x, in_b_end_y} = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Plain cross, full-range diagonals, disjoint and touching boxes, parallel,
    // collinear overlap, endpoint contact at t=0 and t=1, a point segment, t just outside.
    directed = '{
      '{0, 0, 10, 10, 0, 10, 10, 0},
      '{MN, MN, MX, MX, MN, MX, MX, MN},
      '{MX, MN, MN, MX, MN, MN, MX, MX},
      '{0, 0, 1, 1, 5, 5, 6, 7},
      '{0, 0, 2, 2, 2, 0, 4, -2},
      '{0, 0, 4, 0, 0, 1, 4, 1},
      '{0, 0, 4, 0, 2, 0, 6, 0},
      '{0, 0, 4, 4, 0, 4, 4, 0},
      '{0, 0, 4, 0, 0, -2, 0, 2},
      '{0, 0, 4, 0, 4, -2, 4, 2},
      '{3, 3, 3, 3, 0, 0, 6, 6},
      '{0, 0, 3, 1, 1, 3, 2, -1},
      '{0, 0, 3, 0, 4, -1, 2, 1},
      '{-7, -3, 5, 2, -6, 4, 3, -5},
      '{MX, MX, MN, MN, MX, MX, MX, MN},
      '{MN, 0, MX, 0, 0, MN, 0, MX},
      '{-1, -1, 2, 1, 1, -2, -1, 2},
      '{16'sh5555, 16'sh2aaa, -16'sh5556, -16'sh2aab, 0, MX, 1, MN}
    };
    foreach (directed[i]) send_pair(directed[i]);
    // Hold the input off until the pipeline has emptied once.
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : ((ph == 1) ? 85 : 0);
      recv_idle_pct = (ph == 0) ? 85 : ((ph == 1) ? 30 : 0);
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        send_pair(rand_pair());
        // Occasional bursts with no idling at all.
        if ($urandom_range(199) == 0) send_idle_pct = 0;
      end
    end
    drain_results();
    repeat (LATENCY + 8) @(posedge clk);

    $display("Checked %0d results, %0d of them hits, over directed corner cases and random pairs",
             board.checked, board.hits);
    $display("under sender and receiver stalls.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
